/* rtl/core/sha256_pkg.sv */
// SHA-256 package: widths, round constants and initial hash values.
// No dependencies; imported by the top level and the checker.
package sha256_pkg;

    localparam int DataW   = 8;
    localparam int WordW   = 32;
    localparam int BlkW    = 16;   // 32-bit words per block
    localparam int IdxW    = 4;
    localparam int RoundW  = 6;
    localparam int DigNumW = 3;
    localparam int LenW    = 64;

    typedef logic [WordW-1:0] word_t;

    function automatic word_t round_k(input logic [RoundW-1:0] t);
        word_t k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_hash(input logic [DigNumW-1:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    localparam logic [DataW-1:0] PadByte = 8'h80;
    localparam int LenPos = 56;

endpackage

/* rtl/core/sha256_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sha256_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* rtl/core/sha256_byte_stream_hasher_unit.sv */
// SHA-256 byte stream hasher, top level: byte packing, padding, schedule and rounds.
// Depends on sha256_pkg and sha256_ram (the message schedule window).
//
//  channel | dir | tdata                    | tuser         | tlast
//  s_      | in  | [7:0] data_byte          | [0] byte_present | [0] message_end
//  m_      | out | [31:0] digest_word       | [2:0] word_number | [0] final_word
//
// An ordinary byte is packed into the current word; the 64th byte of a block
// starts a compression: each round reads the schedule window, then adds, and
// a final step folds the working vars into the chain. A beat marked last runs
// one or two padding blocks, each packed and compressed in the same way, then
// shows eight digest words on m_. Reset restores the initial hash values and
// clears the fill count and length. Input is held off while padding or a
// compression runs or the digest waits; m_tready stalls only output.
module sha256_byte_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [sha256_pkg::DataW-1:0] s_tdata,   // [7:0] data_byte
    input  logic                     s_tuser,       // [0] byte_present
    input  logic                     s_tlast,       // message_end
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [sha256_pkg::WordW-1:0] m_tdata,   // [31:0] digest_word
    output logic [sha256_pkg::DigNumW-1:0] m_tuser, // [2:0] word_number
    output logic                     m_tlast        // final_word
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StPad  = 3'd1;   // append padding bytes
    localparam logic [2:0] StRead = 3'd2;   // schedule reads in flight
    localparam logic [2:0] StCalc = 3'd3;   // round arithmetic and write back
    localparam logic [2:0] StFin  = 3'd4;   // add working vars into chain
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0]  state_reg, state_next;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       pack_reg;        // bytes being assembled into a word
    logic [5:0]  fill_reg;        // bytes in current block
    logic [63:0] bits_reg;
    logic [RoundW-1:0] round_reg;
    logic        last_reg;        // padding requested, digest follows block
    logic        lenb_reg;        // length goes in this block
    logic [2:0]  onum_reg;
    logic        mid_reg;         // 0x80 appended: later pad bytes are zero/length

    // schedule RAM: four read phases would be slow; use four RAM copies
    // so w[t-2], w[t-7], w[t-15], w[t-16] read together.
    logic        wr_en;
    logic [IdxW-1:0] wr_addr;
    word_t       wr_data;
    logic [IdxW-1:0] ra [4];
    word_t       rd [4];

    for (genvar g = 0; g < 4; g++) begin : g_sched
        sha256_ram #(.Width(WordW), .Depth(BlkW)) u_ram (
            .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
            .rd_addr(ra[g]), .rd_data(rd[g])
        );
    end

    // byte to insert this cycle
    logic        put_en;
    logic [7:0]  put_byte;
    logic        s_fire;
    assign s_tready = (state_reg == StIdle);
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        put_en   = 1'b0;
        put_byte = s_tdata;
        if (s_fire && s_tuser) begin
            put_en = 1'b1;
        end else if (state_reg == StPad) begin
            put_en = 1'b1;
            if (!mid_reg) begin
                put_byte = PadByte;
            end else if (lenb_reg && fill_reg >= 6'(LenPos)) begin
                put_byte = bits_reg[6'(63 - 8 * int'(fill_reg[2:0])) -: 8];
            end else begin
                put_byte = '0;
            end
        end
    end

    // round arithmetic on registered RAM data
    word_t w_t, s0, s1, t1, t2, big0, big1, ch, maj;
    always_comb begin
        s0 = rotr(rd[2], 7) ^ rotr(rd[2], 18) ^ (rd[2] >> 3);
        s1 = rotr(rd[0], 17) ^ rotr(rd[0], 19) ^ (rd[0] >> 10);
        w_t = (round_reg < 6'd16) ? rd[3] : rd[3] + s0 + rd[1] + s1;
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + round_k(round_reg) + w_t;
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    logic [7:0] put_word_b;
    assign put_word_b = put_byte;
    always_comb begin
        ra[0] = IdxW'(round_reg - 6'd2);
        ra[1] = IdxW'(round_reg - 6'd7);
        ra[2] = IdxW'(round_reg - 6'd15);
        ra[3] = IdxW'(round_reg);
        wr_en   = 1'b0;
        wr_addr = fill_reg[5:2];
        wr_data = {pack_reg[23:0], put_word_b};
        if (put_en && fill_reg[1:0] == 2'd3) begin
            wr_en = 1'b1;
        end else if (state_reg == StCalc) begin
            wr_en   = 1'b1;
            wr_addr = IdxW'(round_reg);
            wr_data = w_t;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            StIdle: if (s_fire) begin
                if (s_tuser && fill_reg == 6'd63) state_next = StRead;
                else if (s_tlast) state_next = StPad;
            end
            StPad: if (fill_reg == 6'd63) state_next = StRead;
            StRead: state_next = StCalc;
            StCalc: state_next = (round_reg == 6'd63) ? StFin : StRead;
            StFin: begin
                if (!last_reg) state_next = StIdle;
                else if (lenb_reg) state_next = StOut;
                else state_next = StPad;
            end
            StOut: if (m_tready && onum_reg == 3'd7) state_next = StIdle;
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            last_reg  <= 1'b0;
            lenb_reg  <= 1'b0;
            mid_reg   <= 1'b0;
            onum_reg  <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
        end else begin
            state_reg <= state_next;
            if (put_en) begin
                pack_reg <= {pack_reg[23:0], put_byte};
                fill_reg <= fill_reg + 6'd1;
                // after the 0x80, later pad bytes are zero/length
                if (state_reg == StPad) begin
                    mid_reg <= 1'b1;
                    // length goes in this block only if 0x80 left room
                    if (!mid_reg) lenb_reg <= (fill_reg < 6'(LenPos));
                end
            end
            if (s_fire) begin
                if (s_tuser) bits_reg <= bits_reg + 64'd8;
                last_reg <= s_tlast;
                mid_reg  <= 1'b0;
            end
            if (state_reg == StPad && fill_reg == 6'd63) begin
                round_reg <= '0;
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            end
            if (state_reg == StIdle && s_fire && s_tuser && fill_reg == 6'd63) begin
                round_reg <= '0;
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            end
            if (state_reg == StCalc) begin
                round_reg <= round_reg + 6'd1;
                v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            if (state_reg == StFin) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                if (last_reg && !lenb_reg) begin
                    // second pad block: zeros then length
                    lenb_reg <= 1'b1;
                end
                onum_reg <= '0;
            end
            if (state_reg == StOut && m_tready) begin
                onum_reg <= onum_reg + 3'd1;
                if (onum_reg == 3'd7) begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
                    bits_reg <= '0;
                    fill_reg <= '0;
                    last_reg <= 1'b0;
                    lenb_reg <= 1'b0;
                    mid_reg  <= 1'b0;
                end
            end
        end
    end

    assign m_tvalid = (state_reg == StOut);
    assign m_tdata  = h_reg[onum_reg];
    assign m_tuser  = onum_reg;
    assign m_tlast  = (onum_reg == 3'd7);
endmodule

/* rtl/core/sha256_checker.sv */
// Port-level checker for the hasher, bound to the top level.
// Depends on sha256_pkg.
module sha256_checker
    import sha256_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [sha256_pkg::DigNumW-1:0] m_tuser,
    input logic m_tlast
);
    // output and input never both open
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready)) else $error("input open during digest");
    // final flag only on word seven
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7))) else $error("bad final flag");
    // word numbers advance by one per taken word
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid
            && m_tuser == $past(m_tuser) + 3'd1)) else $error("word order");
    // stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
        else $error("output dropped");
endmodule

bind sha256_byte_stream_hasher_unit sha256_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
